@@ src/assert_macros.svh @@
// Assertion macros for the converter's RTL files; the datapath includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ src/ritp_pkg.sv @@
// Shared types, constants and helpers of the regex infix to postfix converter.
`default_nettype none
package ritp_pkg;

	// Operator stack sizing.
	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);

	// Configuration port sizing and reset values.
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;
	localparam logic [7:0] EPSILON_RST = 8'd36;
	localparam logic [7:0] SYM_LOW_RST = 8'd97;
	localparam logic [7:0] SYM_HIGH_RST = 8'd122;

	// Special characters of the expression language.
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		REG_EPSILON  = 2'd0,
		REG_SYM_LOW  = 2'd1,
		REG_SYM_HIGH = 2'd2
	} reg_idx_t;

	// Codes held on the operator stack; the value orders precedence.
	typedef enum logic [1:0] {
		OP_OPEN = 2'd0,
		OP_ALT  = 2'd1,
		OP_CAT  = 2'd2
	} op_t;

	// Error codes reported on the result channel.
	typedef enum logic [3:0] {
		ERR_NONE           = 4'd0,
		ERR_EMPTY          = 4'd1,
		ERR_UNMATCHED_CLOSE = 4'd2,
		ERR_EMPTY_GROUP    = 4'd3,
		ERR_BARE_STAR      = 4'd4,
		ERR_NO_LEFT        = 4'd5,
		ERR_BAD_CHAR       = 4'd6,
		ERR_UNMATCHED_OPEN = 4'd7,
		ERR_TRAILING_OP    = 4'd8,
		ERR_OVERFLOW       = 4'd9
	} err_t;

	// Source of an emitted postfix character.
	typedef enum logic {
		EMIT_CHAR = 1'b0,
		EMIT_TOP  = 1'b1
	} emit_sel_t;

	// Configuration register values.
	typedef struct packed {
		logic [7:0] epsilon_char;
		logic [7:0] symbol_low;
		logic [7:0] symbol_high;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      latch;
		logic      clear_expr;
		logic      set_discard;
		logic      set_seen;
		logic      emit;
		emit_sel_t emit_sel;
		logic      pop;
		logic      push;
		op_t       push_code;
		logic      grp_inc;
		logic      grp_dec;
		logic      set_want;
		logic      clr_want;
		logic      set_prev;
		logic      clr_prev;
		logic      set_err;
		err_t      err_code;
		logic      out_pend;
		logic      out_last;
		logic      out_term;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic has;
		logic fin;
		logic discarding;
		logic want;
		logic prev;
		logic seen;
		logic is_sym;
		logic is_open;
		logic is_close;
		logic is_star;
		logic is_alt;
		logic is_cat;
		logic cnt_zero;
		logic full;
		op_t  top;
		logic grp_zero;
		logic pend_v;
		logic out_free;
		logic err_v;
	} dp_status_t;

	// Character written out for a stack code.
	function automatic logic [7:0] op_char(input op_t code);
		logic [7:0] ch;
		case (code)
			OP_OPEN: ch = CH_OPEN;
			OP_ALT:  ch = CH_PLUS;
			OP_CAT:  ch = CH_DOT;
			default: ch = CH_OPEN;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

@@ src/regex_infix_to_postfix.sv @@
// Top level of the streaming regular-expression infix to postfix converter.
// Usage:
// Characters of an expression enter on the s_ stream, one per transfer: s_tdata is
// the character, s_tuser[0] says the character is valid (0 for a bare end marker)
// and s_tlast marks the end of the expression. Postfix symbols leave on the m_
// stream: m_tdata is the character, m_tuser the error code and m_tlast marks the
// final result of the expression. On a syntax error one result with character 0,
// m_tlast high and the code is sent and further characters are dropped up to
// the end of the expression; the receiver discards earlier results of it.
// Timing: one character at a time. A plain symbol passes EXEC, FIN and DONE before
// the next ready; a binary operator or ')' adds BIN or CLOSE, an implicit
// concatenation adds BIN and a second EXEC, each popped operator adds a step and
// the final character adds FLUSH; characters dropped after an error stay in IDLE.
// Each result leaves through a single output register, so a stalled receiver
// holds the sequencer only when that register is full.
// Reset clears the expression state and loads the register defaults
// (epsilon 36, symbol range 97 to 122); the stack needs no clearing pass.
// Registers at byte addresses 0, 4, 8: epsilon_char, symbol_low, symbol_high.
`default_nettype none
module regex_infix_to_postfix
	import ritp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Input stream.
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,   // [7:0] character
	input  wire logic              s_tuser,   // [0] has_char
	input  wire logic              s_tlast,
	// Output stream.
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [7:0]        m_tdata,   // [7:0] postfix_char
	output logic      [3:0]        m_tuser,   // [3:0] error_code
	output logic                   m_tlast,
	// Configuration port.
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t st;

	// Configuration registers.
	ritp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer.
	ritp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// Stack, flags and output stage.
	ritp_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st)
	);

endmodule
`default_nettype wire

@@ src/ritp_cfg.sv @@
// Configuration register block behind the APB-style port.
`default_nettype none
module ritp_cfg
	import ritp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes at the end of the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.epsilon_char <= EPSILON_RST;
			cfg_q.symbol_low   <= SYM_LOW_RST;
			cfg_q.symbol_high  <= SYM_HIGH_RST;
		end else if (wr_en) begin
			case (idx)
				REG_EPSILON:  cfg_q.epsilon_char <= pwdata[7:0];
				REG_SYM_LOW:  cfg_q.symbol_low   <= pwdata[7:0];
				REG_SYM_HIGH: cfg_q.symbol_high  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read data, zero extended.
	always_comb begin
		case (idx)
			REG_EPSILON:  prdata = {{(DATA_W-8){1'b0}}, cfg_q.epsilon_char};
			REG_SYM_LOW:  prdata = {{(DATA_W-8){1'b0}}, cfg_q.symbol_low};
			REG_SYM_HIGH: prdata = {{(DATA_W-8){1'b0}}, cfg_q.symbol_high};
			default:      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ src/ritp_dpath.sv @@
// Datapath: input latch, character classes, operator stack, expression flags and output stage.
`default_nettype none
`include "assert_macros.svh"
module ritp_dpath
	import ritp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic [7:0] s_tdata,
	input  wire logic       s_tuser,
	input  wire logic       s_tlast,
	output logic [7:0]      m_tdata,
	output logic [3:0]      m_tuser,
	output logic            m_tlast,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	input  wire dp_cmd_t    cmd,
	output dp_status_t      st
);

	// Latched input item.
	logic [7:0] char_q;
	logic       has_q;
	logic       fin_q;

	// Expression state.
	op_t              op_stack_q [STACK_DEPTH];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] grp_q;
	logic             want_q;
	logic             prev_q;
	logic             seen_q;
	logic             discard_q;
	err_t             err_q;

	// Pending character and output register.
	logic [7:0] pend_q;
	logic       pend_v_q;
	logic [7:0] out_char_q;
	logic       out_last_q;
	err_t       out_err_q;
	logic       out_v_q;

	logic             sym;
	logic [CNT_W-1:0] top_cnt;
	logic [IDX_W-1:0] top_idx;
	logic [IDX_W-1:0] push_idx;
	op_t              top;
	logic [7:0]       emit_char;
	logic             out_load;
	logic             out_free;

	// Character classes; the symbol test has priority over operators.
	assign sym = ((char_q >= cfg.symbol_low) && (char_q <= cfg.symbol_high))
		|| (char_q == cfg.epsilon_char);

	// Top of stack read.
	assign top_cnt  = cnt_q - CNT_W'(1);
	assign top_idx  = top_cnt[IDX_W-1:0];
	assign push_idx = cnt_q[IDX_W-1:0];
	assign top      = op_stack_q[top_idx];

	assign emit_char = (cmd.emit_sel == EMIT_TOP) ? op_char(top) : char_q;
	assign out_free  = !out_v_q || m_tready;
	assign out_load  = (cmd.emit && pend_v_q) || cmd.out_pend || cmd.out_term;

	// Status towards the controller.
	always_comb begin
		st.has        = has_q;
		st.fin        = fin_q;
		st.discarding = discard_q;
		st.want       = want_q;
		st.prev       = prev_q;
		st.seen       = seen_q;
		st.is_sym     = sym;
		st.is_open    = !sym && (char_q == CH_OPEN);
		st.is_close   = !sym && (char_q == CH_CLOSE);
		st.is_star    = !sym && (char_q == CH_STAR);
		st.is_alt     = !sym && (char_q == CH_PLUS);
		st.is_cat     = !sym && (char_q == CH_DOT);
		st.cnt_zero   = (cnt_q == '0);
		st.full       = (cnt_q == CNT_W'(STACK_DEPTH));
		st.top        = top;
		st.grp_zero   = (grp_q == '0);
		st.pend_v     = pend_v_q;
		st.out_free   = out_free;
		st.err_v      = (err_q != ERR_NONE);
	end

	// Input item latch.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			char_q <= s_tdata;
		end
	end

	// Operator stack storage.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			op_stack_q[push_idx] <= cmd.push_code;
		end
	end

	// Expression control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_q     <= 1'b0;
			fin_q     <= 1'b0;
			cnt_q     <= '0;
			grp_q     <= '0;
			want_q    <= 1'b1;
			prev_q    <= 1'b0;
			seen_q    <= 1'b0;
			discard_q <= 1'b0;
			err_q     <= ERR_NONE;
		end else if (cmd.clear_expr) begin
			cnt_q     <= '0;
			grp_q     <= '0;
			want_q    <= 1'b1;
			prev_q    <= 1'b0;
			seen_q    <= 1'b0;
			discard_q <= 1'b0;
			err_q     <= ERR_NONE;
		end else begin
			if (cmd.latch) begin
				has_q <= s_tuser;
				fin_q <= s_tlast;
				err_q <= ERR_NONE;
			end
			if (cmd.set_err) begin
				err_q <= cmd.err_code;
			end
			if (cmd.set_discard) begin
				discard_q <= 1'b1;
			end
			if (cmd.set_seen) begin
				seen_q <= 1'b1;
			end
			if (cmd.push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.pop) begin
				cnt_q <= top_cnt;
			end
			if (cmd.grp_inc) begin
				grp_q <= grp_q + CNT_W'(1);
			end else if (cmd.grp_dec) begin
				grp_q <= grp_q - CNT_W'(1);
			end
			if (cmd.set_want) begin
				want_q <= 1'b1;
			end else if (cmd.clr_want) begin
				want_q <= 1'b0;
			end
			if (cmd.set_prev) begin
				prev_q <= 1'b1;
			end else if (cmd.clr_prev) begin
				prev_q <= 1'b0;
			end
		end
	end

	// Pending character: holds the latest emission until it is known
	// whether it closes the expression.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (cmd.emit) begin
			pend_v_q <= 1'b1;
		end else if (cmd.out_pend) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pend_q <= emit_char;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (cmd.out_term) begin
				out_char_q <= 8'd0;
				out_last_q <= 1'b1;
				out_err_q  <= err_q;
			end else begin
				out_char_q <= pend_q;
				out_last_q <= cmd.out_pend && cmd.out_last;
				out_err_q  <= ERR_NONE;
			end
		end
	end

	assign m_tdata  = out_char_q;
	assign m_tuser  = out_err_q;
	assign m_tlast  = out_last_q;
	assign m_tvalid = out_v_q;

	// Every open group keeps its '(' on the stack.
	`ASSERT_NEVER(a_grp_le_cnt, clk, arst_n, grp_q > cnt_q)
	// A held result is never overwritten.
	`ASSERT_PROP(a_no_overwrite, clk, arst_n, (out_v_q && !m_tready) |-> !out_load)
	// The terminating result never overtakes a pending character.
	`ASSERT_NEVER(a_term_after_pend, clk, arst_n, cmd.out_term && pend_v_q)
	// A pop is only commanded on a non-empty stack.
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, cmd.pop && (cnt_q == '0))

endmodule
`default_nettype wire

@@ src/ritp_ctrl.sv @@
// Controller state machine sequencing one expression character at a time.
`default_nettype none
module ritp_ctrl
	import ritp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_last,
	output logic            in_ready,
	input  wire dp_status_t st,
	output dp_cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_BIN,
		ST_CLOSE,
		ST_FIN,
		ST_FLUSH,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	op_t    code_q;
	op_t    code_d;

	assign in_ready = (state_q == ST_IDLE);

	// State and the code of the binary operator being pushed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			code_q  <= OP_CAT;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		code_d  = code_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (st.discarding) begin
						cmd.clear_expr = in_last;
					end else begin
						cmd.latch = 1'b1;
						state_d   = ST_EXEC;
					end
				end
			end

			ST_EXEC: begin
				if (st.out_free) begin
					if (!st.has) begin
						state_d = ST_FIN;
					end else begin
						cmd.set_seen = 1'b1;
						state_d      = ST_DONE;
						if (st.is_sym || st.is_open) begin
							if (st.prev) begin
								code_d  = OP_CAT;
								state_d = ST_BIN;
							end else if (st.is_sym) begin
								cmd.emit     = 1'b1;
								cmd.emit_sel = EMIT_CHAR;
								cmd.clr_want = 1'b1;
								cmd.set_prev = 1'b1;
								state_d      = ST_FIN;
							end else if (st.full) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = ERR_OVERFLOW;
							end else begin
								cmd.push      = 1'b1;
								cmd.push_code = OP_OPEN;
								cmd.grp_inc   = 1'b1;
								cmd.set_want  = 1'b1;
								cmd.clr_prev  = 1'b1;
								state_d       = ST_FIN;
							end
						end else if (st.is_close) begin
							if (st.grp_zero) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = ERR_UNMATCHED_CLOSE;
							end else if (st.want) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = ERR_EMPTY_GROUP;
							end else begin
								state_d = ST_CLOSE;
							end
						end else if (st.is_star) begin
							if (st.want) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = ERR_BARE_STAR;
							end else begin
								cmd.emit     = 1'b1;
								cmd.emit_sel = EMIT_CHAR;
								cmd.set_prev = 1'b1;
								state_d      = ST_FIN;
							end
						end else if (st.is_alt || st.is_cat) begin
							if (st.want) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = ERR_NO_LEFT;
							end else begin
								code_d  = st.is_alt ? OP_ALT : OP_CAT;
								state_d = ST_BIN;
							end
						end else begin
							cmd.set_err  = 1'b1;
							cmd.err_code = ERR_BAD_CHAR;
						end
					end
				end
			end

			// Pop operators of equal or higher precedence, then push; a full stack is an overflow.
			ST_BIN: begin
				if (st.out_free) begin
					if (!st.cnt_zero && (st.top != OP_OPEN) && (st.top >= code_q)) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EMIT_TOP;
						cmd.pop      = 1'b1;
					end else if (st.full) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ERR_OVERFLOW;
						state_d      = ST_DONE;
					end else begin
						cmd.push      = 1'b1;
						cmd.push_code = code_q;
						cmd.clr_prev  = 1'b1;
						if (st.is_sym || st.is_open) begin
							// Implicit concatenation done; now the operand itself.
							state_d = ST_EXEC;
						end else begin
							cmd.set_want = 1'b1;
							state_d      = ST_FIN;
						end
					end
				end
			end

			// Pop down to the matching '(' and drop it.
			ST_CLOSE: begin
				if (st.out_free) begin
					if (!st.cnt_zero && (st.top != OP_OPEN)) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EMIT_TOP;
						cmd.pop      = 1'b1;
					end else begin
						cmd.pop      = !st.cnt_zero;
						cmd.grp_dec  = 1'b1;
						cmd.clr_want = 1'b1;
						cmd.set_prev = 1'b1;
						state_d      = ST_FIN;
					end
				end
			end

			// End-of-expression checks.
			ST_FIN: begin
				state_d = ST_DONE;
				if (st.fin) begin
					if (!st.seen) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ERR_EMPTY;
					end else if (!st.grp_zero) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ERR_UNMATCHED_OPEN;
					end else if (st.want) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ERR_TRAILING_OP;
					end else begin
						state_d = ST_FLUSH;
					end
				end
			end

			ST_FLUSH: begin
				if (st.out_free) begin
					if (!st.cnt_zero) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EMIT_TOP;
						cmd.pop      = 1'b1;
					end else begin
						state_d = ST_DONE;
					end
				end
			end

			// Send the pending character, then any terminating result.
			ST_DONE: begin
				if (st.out_free) begin
					if (st.pend_v) begin
						cmd.out_pend = 1'b1;
						cmd.out_last = st.fin && !st.err_v;
						if (!st.err_v) begin
							cmd.clear_expr = st.fin;
							state_d        = ST_IDLE;
						end
					end else if (st.err_v || st.fin) begin
						cmd.out_term    = 1'b1;
						cmd.clear_expr  = st.fin;
						cmd.set_discard = !st.fin;
						state_d         = ST_IDLE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ tb/tb_regex_infix_to_postfix.sv @@
// Self-checking testbench of the regex infix to postfix converter, driven by directed and random expressions.
`timescale 1ns / 1ps

import ritp_pkg::*;

// One postfix symbol or error report as it should leave the block.
typedef struct {
	logic [7:0] ch;
	logic       last;
	err_t       code;
} postfix_res_t;

// Tracks the conversion of each expression and checks the output stream against it.
class postfix_tracker;
	logic [7:0]   eps;
	logic [7:0]   sym_lo;
	logic [7:0]   sym_hi;
	op_t          ops[STACK_DEPTH];
	int unsigned  depth;
	int unsigned  groups;
	bit           awaiting_operand;
	bit           after_closer;
	bit           any_char;
	bit           dropping;
	postfix_res_t expected_postfix[$];
	int unsigned  failures;

	function new();
		eps      = EPSILON_RST;
		sym_lo   = SYM_LOW_RST;
		sym_hi   = SYM_HIGH_RST;
		failures = 0;
		clear_expr();
	endfunction

	function void clear_expr();
		depth            = 0;
		groups           = 0;
		awaiting_operand = 1'b1;
		after_closer     = 1'b0;
		any_char         = 1'b0;
		dropping         = 1'b0;
	endfunction

	function void set_reg(reg_idx_t idx, logic [7:0] v);
		case (idx)
			REG_EPSILON:  eps = v;
			REG_SYM_LOW:  sym_lo = v;
			REG_SYM_HIGH: sym_hi = v;
			default: ;
		endcase
	endfunction

	function void add(logic [7:0] ch, logic last, err_t code);
		postfix_res_t r;
		r.ch   = ch;
		r.last = last;
		r.code = code;
		expected_postfix.insert(expected_postfix.size(), r);
	endfunction

	function logic [7:0] op_symbol(op_t code);
		case (code)
			OP_ALT:  return CH_PLUS;
			OP_CAT:  return CH_DOT;
			default: return CH_OPEN;
		endcase
	endfunction

	// Pops operators of equal or higher precedence down to a group, then pushes.
	function err_t push_binary(op_t code);
		while (depth > 0 && ops[depth-1] != OP_OPEN && ops[depth-1] >= code) begin
			depth--;
			add(op_symbol(ops[depth]), 1'b0, ERR_NONE);
		end
		if (depth >= STACK_DEPTH)
			return ERR_OVERFLOW;
		ops[depth] = code;
		depth++;
		return ERR_NONE;
	endfunction

	function err_t take_char(logic [7:0] c);
		bit   sym;
		err_t e;
		sym      = (c >= sym_lo && c <= sym_hi) || c == eps;
		any_char = 1'b1;
		// Symbols and group openers, with an implicit concatenation in front.
		if (sym || c == CH_OPEN) begin
			if (after_closer) begin
				e = push_binary(OP_CAT);
				if (e != ERR_NONE)
					return e;
			end
			if (sym) begin
				add(c, 1'b0, ERR_NONE);
				awaiting_operand = 1'b0;
				after_closer     = 1'b1;
			end else begin
				if (depth >= STACK_DEPTH)
					return ERR_OVERFLOW;
				ops[depth] = OP_OPEN;
				depth++;
				groups++;
				awaiting_operand = 1'b1;
				after_closer     = 1'b0;
			end
			return ERR_NONE;
		end
		// Group closer: unwind the stack down to the matching opener.
		if (c == CH_CLOSE) begin
			if (groups == 0)
				return ERR_UNMATCHED_CLOSE;
			if (awaiting_operand)
				return ERR_EMPTY_GROUP;
			while (depth > 0 && ops[depth-1] != OP_OPEN) begin
				depth--;
				add(op_symbol(ops[depth]), 1'b0, ERR_NONE);
			end
			if (depth > 0)
				depth--;
			groups--;
			awaiting_operand = 1'b0;
			after_closer     = 1'b1;
			return ERR_NONE;
		end
		if (c == CH_STAR) begin
			if (awaiting_operand)
				return ERR_BARE_STAR;
			add(c, 1'b0, ERR_NONE);
			after_closer = 1'b1;
			return ERR_NONE;
		end
		if (c == CH_PLUS || c == CH_DOT) begin
			if (awaiting_operand)
				return ERR_NO_LEFT;
			e = push_binary((c == CH_PLUS) ? OP_ALT : OP_CAT);
			if (e != ERR_NONE)
				return e;
			awaiting_operand = 1'b1;
			after_closer     = 1'b0;
			return ERR_NONE;
		end
		return ERR_BAD_CHAR;
	endfunction

	// Works out the results caused by one accepted input transfer.
	function void note_input(logic [7:0] c, logic has, logic fin);
		err_t        e;
		int unsigned base;
		if (dropping) begin
			if (fin)
				clear_expr();
			return;
		end
		base = expected_postfix.size();
		e    = ERR_NONE;
		if (has)
			e = take_char(c);
		if (e == ERR_NONE && fin) begin
			if (!any_char)
				e = ERR_EMPTY;
			else if (groups != 0)
				e = ERR_UNMATCHED_OPEN;
			else if (awaiting_operand)
				e = ERR_TRAILING_OP;
		end
		if (e != ERR_NONE) begin
			add(8'h00, 1'b1, e);
			if (fin)
				clear_expr();
			else
				dropping = 1'b1;
			return;
		end
		// End of expression: flush the stack and mark the last symbol.
		if (fin) begin
			while (depth > 0) begin
				depth--;
				add(op_symbol(ops[depth]), 1'b0, ERR_NONE);
			end
			if (expected_postfix.size() == base)
				add(8'h00, 1'b1, ERR_NONE);
			else
				expected_postfix[expected_postfix.size()-1].last = 1'b1;
			clear_expr();
		end
	endfunction

	// Compares one output transfer with the oldest expected result.
	function void check_output(logic [7:0] ch, logic last, logic [3:0] code);
		postfix_res_t r;
		if (expected_postfix.size() == 0) begin
			$display("%0t: unexpected result char %h last %0b code %0d",
				$time, ch, last, code);
			failures++;
			return;
		end
		r = expected_postfix.pop_front();
		if (ch !== r.ch || last !== r.last || code !== r.code) begin
			$display("%0t: expected char %h last %0b code %0d, got char %h last %0b code %0d",
				$time, r.ch, r.last, r.code, ch, last, code);
			failures++;
		end
	endfunction
endclass

module tb_regex_infix_to_postfix;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 43;
	localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 16;
	localparam int STALL_LIMIT  = 1000;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata  = '0;
	logic              s_tuser  = 1'b0;
	logic              s_tlast  = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;
	logic [3:0]        m_tuser;
	logic              m_tlast;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	postfix_tracker tracker = new();
	logic [7:0]     expr_text[$];
	int unsigned    sent_items = 0;
	bit             quiet = 1'b0;
	int unsigned    out_hold = 0;
	int unsigned    out_gap;
	int unsigned    idle_cycles = 0;

	regex_infix_to_postfix DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	function automatic int unsigned draw_gap();
		return quiet ? 0 : $urandom_range(0, 5);
	endfunction

	// Output side: check each transfer, then stall for a random number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_hold <= 0;
		end else if (m_tvalid && m_tready) begin
			tracker.check_output(m_tdata, m_tlast, m_tuser);
			out_gap = draw_gap();
			m_tready <= (out_gap == 0);
			out_hold <= out_gap;
		end else if (out_hold > 0) begin
			out_hold <= out_hold - 1;
			m_tready <= (out_hold == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles in which nothing moves on any port.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
				idle_cycles <= 0;
			end else if (idle_cycles == STALL_LIMIT) begin
				$display("%0t: watchdog expired with %0d results outstanding",
					$time, tracker.expected_postfix.size());
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// One input transfer, preceded by a random gap.
	task automatic send_item(input logic [7:0] ch, input logic has, input logic fin);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tuser  <= has;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		tracker.note_input(ch, has, fin);
		if (has || fin)
			sent_items++;
	endtask

	// Sends the buffered expression, optionally closed by a bare end marker.
	task automatic send_expr(input bit bare_end, input bit noisy);
		int i;
		for (i = 0; i < expr_text.size(); i++) begin
			if (noisy && $urandom_range(0, 15) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(expr_text[i], 1'b1, (i == expr_text.size() - 1) && !bare_end);
		end
		if (bare_end || expr_text.size() == 0)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// Appends one character to the buffered expression.
	function automatic void append_char(input logic [7:0] c);
		expr_text.insert(expr_text.size(), c);
	endfunction

	task automatic send_text(input string s, input bit bare_end);
		int i;
		expr_text.delete();
		for (i = 0; i < s.len(); i++)
			append_char(s[i]);
		send_expr(bare_end, 1'b0);
	endtask

	function automatic logic [7:0] pick_symbol();
		if (tracker.sym_lo > tracker.sym_hi || $urandom_range(0, 7) == 0)
			return tracker.eps;
		return 8'($urandom_range(tracker.sym_hi, tracker.sym_lo));
	endfunction

	// Builds a random expression: mostly well formed, sometimes deep, sometimes damaged.
	task automatic build_expr();
		int          kind;
		int          n;
		int          i;
		int          pos;
		int unsigned opens;
		bit          awaiting;
		expr_text.delete();
		kind = $urandom_range(0, 15);
		if (kind == 0) begin
			// Nested groups around the stack limit.
			n = $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 2);
			repeat (n) append_char(CH_OPEN);
			append_char(pick_symbol());
			repeat (n) append_char(CH_CLOSE);
		end else if (kind == 1) begin
			// Alternatives nested in groups pile two entries per level.
			n = $urandom_range(5, 9);
			repeat (n) begin
				append_char(pick_symbol());
				append_char(CH_PLUS);
				append_char(CH_OPEN);
			end
			append_char(pick_symbol());
			repeat (n) append_char(CH_CLOSE);
		end else begin
			awaiting = 1'b1;
			opens    = 0;
			n        = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 10);
			for (i = 0; i < n; i++) begin
				if (awaiting) begin
					if (opens < 4 && $urandom_range(0, 3) == 0) begin
						append_char(CH_OPEN);
						opens++;
					end else begin
						append_char(pick_symbol());
						awaiting = 1'b0;
					end
				end else begin
					case ($urandom_range(0, 5))
						0: append_char(CH_STAR);
						1: begin
							append_char(CH_PLUS);
							awaiting = 1'b1;
						end
						2: begin
							append_char(CH_DOT);
							awaiting = 1'b1;
						end
						3: begin
							if (opens > 0) begin
								append_char(CH_CLOSE);
								opens--;
							end else begin
								append_char(CH_STAR);
							end
						end
						4: begin
							if (opens < 4) begin
								append_char(CH_OPEN);
								opens++;
								awaiting = 1'b1;
							end else begin
								append_char(pick_symbol());
							end
						end
						default: append_char(pick_symbol());
					endcase
				end
			end
			if (awaiting)
				append_char(pick_symbol());
			repeat (opens) append_char(CH_CLOSE);
		end
		// Damage about one expression in five.
		if ($urandom_range(0, 4) == 0) begin
			pos = $urandom_range(0, expr_text.size() - 1);
			case ($urandom_range(0, 2))
				0: expr_text[pos] = 8'($urandom_range(0, 255));
				1: begin
					case ($urandom_range(0, 5))
						0: expr_text.insert(pos, CH_OPEN);
						1: expr_text.insert(pos, CH_CLOSE);
						2: expr_text.insert(pos, CH_STAR);
						3: expr_text.insert(pos, CH_PLUS);
						4: expr_text.insert(pos, CH_DOT);
						default: expr_text.insert(pos, 8'($urandom_range(0, 255)));
					endcase
				end
				default: expr_text.pop_back();
			endcase
		end
	endtask

	// One register access; the bus is left idle afterwards.
	task automatic apb_access(input bit wr, input reg_idx_t idx, input logic [7:0] wdata,
			output logic [DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_W'(4 * int'(idx));
		pwdata  <= DATA_W'(wdata);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(input reg_idx_t idx, input logic [7:0] v);
		logic [DATA_W-1:0] rd;
		apb_access(1'b0, idx, 8'h00, rd);
		if (rd !== DATA_W'(v)) begin
			$display("%0t: register %0d expected %h, got %h", $time, idx, DATA_W'(v), rd);
			tracker.failures++;
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
		logic [DATA_W-1:0] rd;
		apb_access(1'b1, idx, v, rd);
		tracker.set_reg(idx, v);
		check_reg(idx, v);
	endtask

	// Lets the block drain: all results in, then its longest silent processing.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (tracker.expected_postfix.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_phase_config(input int p);
		case (p)
			1: begin
				// Everything is a symbol.
				write_reg(REG_EPSILON, 8'h00);
				write_reg(REG_SYM_LOW, 8'h00);
				write_reg(REG_SYM_HIGH, 8'hFF);
			end
			2: begin
				write_reg(REG_EPSILON, 8'hFF);
				write_reg(REG_SYM_LOW, "0");
				write_reg(REG_SYM_HIGH, "9");
			end
			3: begin
				// Epsilon shadows the star operator.
				write_reg(REG_EPSILON, CH_STAR);
				write_reg(REG_SYM_LOW, "A");
				write_reg(REG_SYM_HIGH, "Z");
			end
			4: begin
				// Empty symbol range: only epsilon is an operand.
				write_reg(REG_EPSILON, "~");
				write_reg(REG_SYM_LOW, 8'd200);
				write_reg(REG_SYM_HIGH, 8'd100);
			end
			5: begin
				write_reg(REG_EPSILON, 8'($urandom_range(0, 255)));
				write_reg(REG_SYM_LOW, 8'($urandom_range(0, 255)));
				write_reg(REG_SYM_HIGH, 8'($urandom_range(0, 255)));
			end
			default: begin
				write_reg(REG_EPSILON, EPSILON_RST);
				write_reg(REG_SYM_LOW, SYM_LOW_RST);
				write_reg(REG_SYM_HIGH, SYM_HIGH_RST);
			end
		endcase
	endtask

	// Directed expressions: every operator and each kind of syntax error but stack overflow.
	task automatic run_directed();
		send_text("(ab)*+c.$", 1'b0);
		send_text("a", 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_text(")", 1'b0);
		send_text("()", 1'b0);
		send_text("*", 1'b0);
		send_text("+", 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item("a", 1'b1, 1'b1);
		send_text("(a", 1'b0);
		send_text("a+", 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
	endtask

	initial begin
		int p;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_reg(REG_EPSILON, EPSILON_RST);
		check_reg(REG_SYM_LOW, SYM_LOW_RST);
		check_reg(REG_SYM_HIGH, SYM_HIGH_RST);
		for (p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				wait_idle();
				load_phase_config(p);
			end else begin
				run_directed();
			end
			while (sent_items < (p + 1) * PHASE_ITEMS) begin
				quiet <= ($urandom_range(0, 5) == 0);
				build_expr();
				send_expr($urandom_range(0, 4) == 0, 1'b1);
			end
		end
		wait_idle();
		if (tracker.failures == 0 && tracker.expected_postfix.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
